FILE: design/arprr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_pkg
// Shared types, codes and constants of the ARP receive responder.
// ----------------------------------------------------------------------------
package arprr_pkg;

    // APB data and address widths: the MAC register needs 64-bit data, 8-byte slots
    localparam int DataW = 64;
    localparam int AddrW = 5;

    // Constants checked on every packet, and the reset value of the hardware length
    localparam logic [15:0] HwTypeEth   = 16'h0001;
    localparam logic [15:0] ProtoIpv4   = 16'h0800;
    localparam logic [7:0]  ProtoLenV4  = 8'd4;
    localparam logic [7:0]  HwLenReset  = 8'd6;
    localparam logic [7:0]  LoopOctet   = 8'd127;
    localparam logic [3:0]  McastNibble = 4'hE;

    // Link classification codes
    typedef enum logic [1:0] {
        CLS_HOST  = 2'd0,
        CLS_BCAST = 2'd1,
        CLS_MCAST = 2'd2,
        CLS_OTHER = 2'd3
    } t_class;

    // ARP opcodes of interest
    localparam logic [15:0] OpRequest = 16'd1;
    localparam logic [15:0] OpReply   = 16'd2;

    // Result codes
    typedef enum logic [2:0] {
        VERDICT_HANDLED    = 3'd0,
        VERDICT_BAD_HDR    = 3'd1,
        VERDICT_BAD_TARGET = 3'd2,
        VERDICT_NOT_OURS   = 3'd3,
        VERDICT_BAD_OP     = 3'd4
    } t_verdict;

    // Register indexes (byte address = 8 * index)
    typedef enum logic [1:0] {
        REG_ARP_DISABLED = 2'd0,
        REG_HW_ADDR_LEN  = 2'd1,
        REG_OUR_IP       = 2'd2,
        REG_OUR_MAC      = 2'd3
    } t_reg_idx;

    // Configuration seen by the decision logic
    typedef struct packed {
        logic        arp_disabled;
        logic [7:0]  hw_addr_len;
        logic [31:0] our_ip;
        logic [47:0] our_mac;
    } t_cfg;

    // One decoded ARP packet
    typedef struct packed {
        logic [1:0]  packet_class;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] tgt_ip;
    } t_arp_in;

    // One result item
    typedef struct packed {
        t_verdict    verdict;
        logic        learn_valid;
        logic [47:0] learn_mac;
        logic [31:0] learn_ip;
        logic        reply_valid;
        logic [47:0] reply_src_mac;
        logic [31:0] reply_src_ip;
        logic [47:0] reply_dst_mac;
        logic [31:0] reply_dst_ip;
        logic        release_queue;
    } t_result;

endpackage

FILE: design/arprr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_cfg
// APB register file: ARP enable, hardware length, interface IP and MAC.
// ----------------------------------------------------------------------------
module arprr_cfg import arprr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[AddrW-1:3]);
    assign w_wr   = psel && penable && pwrite;

    // register writes at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arp_disabled <= 1'b0;
            r_cfg.hw_addr_len  <= HwLenReset;
            r_cfg.our_ip       <= '0;
            r_cfg.our_mac      <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ARP_DISABLED: r_cfg.arp_disabled <= pwdata[0];
                REG_HW_ADDR_LEN:  r_cfg.hw_addr_len  <= pwdata[7:0];
                REG_OUR_IP:       r_cfg.our_ip       <= pwdata[31:0];
                REG_OUR_MAC:      r_cfg.our_mac      <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_ARP_DISABLED: prdata = {{(DataW-1){1'b0}}, r_cfg.arp_disabled};
            REG_HW_ADDR_LEN:  prdata = {{(DataW-8){1'b0}}, r_cfg.hw_addr_len};
            REG_OUR_IP:       prdata = {{(DataW-32){1'b0}}, r_cfg.our_ip};
            REG_OUR_MAC:      prdata = {{(DataW-48){1'b0}}, r_cfg.our_mac};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/arprr_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arprr_decide
// Checks one ARP packet against the interface setup and builds its result.
// ----------------------------------------------------------------------------
module arprr_decide import arprr_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_arp_in i_pkt,
    output t_result o_res
);

    logic     bad_hdr;
    logic     bad_tgt;
    logic     ours;
    logic     learn;
    logic     reply;
    logic     release_q;
    t_verdict verdict;

    // header and class check, then target range, then ownership
    assign bad_hdr = (t_class'(i_pkt.packet_class) == CLS_OTHER) || i_cfg.arp_disabled
                  || (i_pkt.hw_type != HwTypeEth) || (i_pkt.proto_type != ProtoIpv4)
                  || (i_pkt.hw_len != i_cfg.hw_addr_len) || (i_pkt.proto_len != ProtoLenV4);
    assign bad_tgt = (i_pkt.tgt_ip[31:24] == LoopOctet)
                  || (i_pkt.tgt_ip[31:28] == McastNibble);
    assign ours    = (i_pkt.tgt_ip == i_cfg.our_ip);

    // verdict priority chain
    always_comb begin
        verdict   = VERDICT_BAD_OP;
        learn     = 1'b0;
        reply     = 1'b0;
        release_q = 1'b0;
        if (bad_hdr) begin
            verdict = VERDICT_BAD_HDR;
        end else if (bad_tgt) begin
            verdict = VERDICT_BAD_TARGET;
        end else if (!ours) begin
            // gratuitous announcement still teaches the binding
            verdict = VERDICT_NOT_OURS;
            learn   = (i_pkt.tgt_ip == i_pkt.sender_ip);
        end else if (i_pkt.arp_opcode == OpReply) begin
            verdict   = VERDICT_HANDLED;
            learn     = 1'b1;
            release_q = 1'b1;
        end else if (i_pkt.arp_opcode == OpRequest) begin
            verdict = VERDICT_HANDLED;
            learn   = 1'b1;
            reply   = 1'b1;
        end
    end

    // address fields are zero when their valid is low
    assign o_res.verdict       = verdict;
    assign o_res.learn_valid   = learn;
    assign o_res.learn_mac     = learn ? i_pkt.sender_mac : '0;
    assign o_res.learn_ip      = learn ? i_pkt.sender_ip  : '0;
    assign o_res.reply_valid   = reply;
    assign o_res.reply_src_mac = reply ? i_cfg.our_mac    : '0;
    assign o_res.reply_src_ip  = reply ? i_pkt.tgt_ip     : '0;
    assign o_res.reply_dst_mac = reply ? i_pkt.sender_mac : '0;
    assign o_res.reply_dst_ip  = reply ? i_pkt.sender_ip  : '0;
    assign o_res.release_queue = release_q;

endmodule

FILE: design/arp_receive_responder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_receive_responder_top
// Decides drop, learn, reply and queue release for each received ARP packet.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: i_in_valid with the decoded packet fields; o_in_stall
//    back to the source. A transfer happens when valid is high and stall low.
//  - Output channel: o_out_valid with the result fields; i_out_stall from
//    the sink. Exactly one result per accepted packet, in order.
//  - Each result passes the input register, then the result register
//    after the check logic.
//  - Throughput: one packet per cycle while the sink does not stall,
//    set by the two-register pipeline.
//  - When the sink stalls, the result register holds; the input register
//    still accepts one more packet, then o_in_stall rises until the sink
//    takes the result.
//  - Reset (synchronous, active low) empties both stages and restores the
//    registers: ARP enabled, hardware length 6, IP and MAC zero.
//  - Registers on APB at byte address 8*index, 64-bit data; write only
//    while the block is idle.
// ----------------------------------------------------------------------------
module arp_receive_responder_top import arprr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    // packet input
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_packet_class,
    input  logic [15:0]      i_hw_type,
    input  logic [15:0]      i_proto_type,
    input  logic [7:0]       i_hw_len,
    input  logic [7:0]       i_proto_len,
    input  logic [15:0]      i_arp_opcode,
    input  logic [47:0]      i_sender_mac,
    input  logic [31:0]      i_sender_ip,
    input  logic [31:0]      i_tgt_ip,
    // result output
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_verdict,
    output logic             o_learn_valid,
    output logic [47:0]      o_learn_mac,
    output logic [31:0]      o_learn_ip,
    output logic             o_reply_valid,
    output logic [47:0]      o_reply_src_mac,
    output logic [31:0]      o_reply_src_ip,
    output logic [47:0]      o_reply_dst_mac,
    output logic [31:0]      o_reply_dst_ip,
    output logic             o_release_queue
);

    t_cfg    w_cfg;
    t_arp_in r_pkt;
    logic    r_pkt_vld;
    t_result w_res;
    t_result r_res;
    logic    r_res_vld;
    logic    out_adv;
    logic    in_adv;

    arprr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // pipeline advance: result stage moves when empty or drained
    assign out_adv    = !r_res_vld || !i_out_stall;
    assign in_adv     = !r_pkt_vld || out_adv;
    assign o_in_stall = !in_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_vld <= 1'b0;
        end else if (in_adv) begin
            r_pkt_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_pkt.packet_class <= i_packet_class;
            r_pkt.hw_type      <= i_hw_type;
            r_pkt.proto_type   <= i_proto_type;
            r_pkt.hw_len       <= i_hw_len;
            r_pkt.proto_len    <= i_proto_len;
            r_pkt.arp_opcode   <= i_arp_opcode;
            r_pkt.sender_mac   <= i_sender_mac;
            r_pkt.sender_ip    <= i_sender_ip;
            r_pkt.tgt_ip       <= i_tgt_ip;
        end
    end

    arprr_decide u_decide (
        .i_cfg (w_cfg),
        .i_pkt (r_pkt),
        .o_res (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (out_adv) begin
            r_res_vld <= r_pkt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_pkt_vld) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_res_vld;
    assign o_verdict       = r_res.verdict;
    assign o_learn_valid   = r_res.learn_valid;
    assign o_learn_mac     = r_res.learn_mac;
    assign o_learn_ip      = r_res.learn_ip;
    assign o_reply_valid   = r_res.reply_valid;
    assign o_reply_src_mac = r_res.reply_src_mac;
    assign o_reply_src_ip  = r_res.reply_src_ip;
    assign o_reply_dst_mac = r_res.reply_dst_mac;
    assign o_reply_dst_ip  = r_res.reply_dst_ip;
    assign o_release_queue = r_res.release_queue;

endmodule
